/* design/quaternion_arithmetic_unit_assert.svh */
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit_assert.svh
// Assertion macros shared by the quaternion arithmetic unit.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_ARITHMETIC_UNIT_ASSERT_SVH
`define QUATERNION_ARITHMETIC_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define QAU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define QAU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/qau_pkg.sv */
// ----------------------------------------------------------------------------
// qau_pkg
// Types, constants and fixed-point helpers of the quaternion arithmetic unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qau_pkg;

  localparam int QW     = 16;  // Q1.14 component
  localparam int SW     = 32;  // Q3.28 scalar
  localparam int FRAC   = 14;
  localparam int PW     = 2 * QW;         // one exact product
  localparam int ACCW   = PW + 2;         // sum of four products
  localparam int VW     = ACCW - FRAC;    // vector value before clamp
  localparam logic signed [ACCW-1:0] RND_HALF = ACCW'(1) <<< (FRAC - 1);

  typedef enum logic [2:0] {
    OP_MUL  = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_SCL  = 3'd3,
    OP_NEG  = 3'd4,
    OP_CONJ = 3'd5,
    OP_DOT  = 3'd6,
    OP_LEN2 = 3'd7
  } op_t;

  typedef logic signed [QW-1:0] q14_t;

  typedef struct packed {
    op_t  op;
    q14_t ax, ay, az, aw;
    q14_t bx, by, bz, bw;
    q14_t factor;
  } item_t;

  typedef struct packed {
    q14_t                 rx, ry, rz, rw;
    logic signed [SW-1:0] scalar_out;
    logic                 overflow;
  } result_t;

  // Round half up to 14 fraction bits.
  function automatic logic signed [VW-1:0] rnd14(input logic signed [ACCW-1:0] v);
    logic signed [ACCW-1:0] t;
    t = v + RND_HALF;
    return t[ACCW-1:FRAC];
  endfunction

  function automatic logic ovf16(input logic signed [VW-1:0] v);
    return (v > VW'(32767)) || (v < -VW'(32768));
  endfunction

  function automatic q14_t sat16(input logic signed [VW-1:0] v);
    q14_t r;
    if (v > VW'(32767)) begin
      r = 16'sh7FFF;
    end else if (v < -VW'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[QW-1:0];
    end
    return r;
  endfunction

  function automatic logic ovf32(input logic signed [ACCW-1:0] v);
    return (v[ACCW-1:SW-1] != '0) && (v[ACCW-1:SW-1] != '1);
  endfunction

  function automatic logic signed [SW-1:0] sat32(input logic signed [ACCW-1:0] v);
    logic signed [SW-1:0] r;
    if (!ovf32(v)) begin
      r = v[SW-1:0];
    end else if (v[ACCW-1]) begin
      r = {1'b1, {(SW-1){1'b0}}};
    end else begin
      r = {1'b0, {(SW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

/* design/qau_req_if.sv */
// ----------------------------------------------------------------------------
// qau_req_if
// Request channel: operation code, two quaternions and a scale factor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface qau_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic signed [15:0] ax, ay, az, aw;
  logic signed [15:0] bx, by, bz, bw;
  logic signed [15:0] factor;

  modport source (output valid, op, ax, ay, az, aw, bx, by, bz, bw, factor,
                  input ready);
  modport sink   (input valid, op, ax, ay, az, aw, bx, by, bz, bw, factor,
                  output ready);
endinterface

/* design/qau_rsp_if.sv */
// ----------------------------------------------------------------------------
// qau_rsp_if
// Response channel: quaternion result, scalar result and overflow flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface qau_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] rx, ry, rz, rw;
  logic signed [31:0] scalar_out;
  logic               overflow;

  modport source (output valid, rx, ry, rz, rw, scalar_out, overflow,
                  input ready);
  modport sink   (input valid, rx, ry, rz, rw, scalar_out, overflow,
                  output ready);
endinterface

/* design/qau_datapath.sv */
// ----------------------------------------------------------------------------
// qau_datapath
// Operation logic: one shared 4x4 product array feeds the Hamilton product,
// scale, dot and squared length; rounding and clamping follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qau_datapath (
  input  qau_pkg::item_t   item,
  output qau_pkg::result_t res
);
  import qau_pkg::*;

  q14_t                   av [4];
  q14_t                   bv [4];
  logic signed [PW-1:0]   pr [4][4];
  logic signed [ACCW-1:0] ham [4];
  logic signed [ACCW-1:0] dsum;
  logic signed [VW-1:0]   v [4];
  logic                   vec_ovf;
  logic                   is_scalar;

  assign av[0] = item.ax;
  assign av[1] = item.ay;
  assign av[2] = item.az;
  assign av[3] = item.aw;

  // Scale pairs each component with the factor; squared length with itself.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      case (item.op)
        OP_SCL:  bv[i] = item.factor;
        OP_LEN2: bv[i] = av[i];
        default: bv[i] = (i == 0) ? item.bx : (i == 1) ? item.by :
                         (i == 2) ? item.bz : item.bw;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        pr[i][j] = PW'(av[i] * bv[j]);
      end
    end
  end

  // Index order x, y, z, w.
  assign ham[0] = ACCW'(pr[3][0]) + ACCW'(pr[0][3]) + ACCW'(pr[1][2]) - ACCW'(pr[2][1]);
  assign ham[1] = ACCW'(pr[3][1]) - ACCW'(pr[0][2]) + ACCW'(pr[1][3]) + ACCW'(pr[2][0]);
  assign ham[2] = ACCW'(pr[3][2]) + ACCW'(pr[0][1]) - ACCW'(pr[1][0]) + ACCW'(pr[2][3]);
  assign ham[3] = ACCW'(pr[3][3]) - ACCW'(pr[0][0]) - ACCW'(pr[1][1]) - ACCW'(pr[2][2]);
  assign dsum   = ACCW'(pr[0][0]) + ACCW'(pr[1][1]) + ACCW'(pr[2][2]) + ACCW'(pr[3][3]);

  always_comb begin
    is_scalar = 1'b0;
    for (int i = 0; i < 4; i++) begin
      case (item.op)
        OP_MUL:  v[i] = rnd14(ham[i]);
        OP_ADD:  v[i] = VW'(av[i]) + VW'(bv[i]);
        OP_SUB:  v[i] = VW'(av[i]) - VW'(bv[i]);
        OP_SCL:  v[i] = rnd14(ACCW'(pr[i][i]));
        OP_NEG:  v[i] = -VW'(av[i]);
        OP_CONJ: v[i] = (i == 3) ? VW'(av[i]) : -VW'(av[i]);
        default: v[i] = '0;
      endcase
    end
    if (item.op inside {OP_DOT, OP_LEN2}) begin
      is_scalar = 1'b1;
    end
  end

  assign vec_ovf = ovf16(v[0]) | ovf16(v[1]) | ovf16(v[2]) | ovf16(v[3]);

  always_comb begin
    if (is_scalar) begin
      res.rx         = '0;
      res.ry         = '0;
      res.rz         = '0;
      res.rw         = '0;
      res.scalar_out = sat32(dsum);
      res.overflow   = ovf32(dsum);
    end else begin
      res.rx         = sat16(v[0]);
      res.ry         = sat16(v[1]);
      res.rz         = sat16(v[2]);
      res.rw         = sat16(v[3]);
      res.scalar_out = '0;
      res.overflow   = vec_ovf;
    end
  end

endmodule

/* design/quaternion_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit
// Quaternion ALU in Q1.14: Hamilton product, add, subtract, scale, negate,
// conjugate, dot product and squared length, with saturation.
//
//   channel  dir  payload                                      width
//   req      in   op, ax..aw, bx..bw, factor                   3 + 9x16
//   rsp      out  rx, ry, rz, rw, scalar_out, overflow         4x16 + 32 + 1
//
// One request per cycle unless rsp stalls. Each request passes an input
// register, then the operation logic into a result register that drives rsp;
// each takes a single pass through the 16-product array.
// A stall on rsp holds the result register; the input register still takes
// one more request, then req.ready drops until the result moves.
// Synchronous rst empties both registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quaternion_arithmetic_unit (
  input  logic      clk,
  input  logic      rst,
  qau_req_if.sink   req,
  qau_rsp_if.source rsp
);
  import qau_pkg::*;

  `include "quaternion_arithmetic_unit_assert.svh"

  item_t   s1_item;
  logic    s1_valid;
  result_t s2_res;
  result_t res_next;
  logic    s2_valid;
  logic    s2_load;
  logic    s1_load;

  assign s2_load   = s1_valid && (!s2_valid || rsp.ready);
  assign req.ready = !s1_valid || s2_load;
  assign s1_load   = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= 1'b1;
      end else if (s2_load) begin
        s1_valid <= 1'b0;
      end
      if (s2_load) begin
        s2_valid <= 1'b1;
      end else if (rsp.ready) begin
        s2_valid <= 1'b0;
      end
    end
  end

  // Payload registers: load on transfer, hold otherwise.
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_item <= '{op: op_t'(req.op),
                   ax: req.ax, ay: req.ay, az: req.az, aw: req.aw,
                   bx: req.bx, by: req.by, bz: req.bz, bw: req.bw,
                   factor: req.factor};
    end
    if (s2_load) begin
      s2_res <= res_next;
    end
  end

  qau_datapath u_datapath (
    .item (s1_item),
    .res  (res_next)
  );

  assign rsp.valid      = s2_valid;
  assign rsp.rx         = s2_res.rx;
  assign rsp.ry         = s2_res.ry;
  assign rsp.rz         = s2_res.rz;
  assign rsp.rw         = s2_res.rw;
  assign rsp.scalar_out = s2_res.scalar_out;
  assign rsp.overflow   = s2_res.overflow;

  `QAU_ASSERT_NXT(a_req_lands, s1_load, s1_valid, "accepted request not held in input register")
  `QAU_ASSERT_NXT(a_empty_moves, s1_valid && !s2_valid, s2_valid, "input item did not advance")
  `QAU_ASSERT_IMP(a_scalar_excl, s2_valid && (s2_res.scalar_out != '0),
                  (s2_res.rx == '0) && (s2_res.ry == '0) &&
                  (s2_res.rz == '0) && (s2_res.rw == '0),
                  "scalar result with nonzero vector fields")
  `QAU_ASSERT_NXT(a_stall_holds, s2_valid && !rsp.ready && s1_valid, s1_valid && s2_valid,
                  "item dropped during output stall")

endmodule

/* sim/tb_quaternion_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// tb_quaternion_arithmetic_unit
// Drives quaternion requests through the arithmetic unit and checks every
// response against a cycle-free predictor of the eight operations. Requests
// come from a queue, with directed corner cases first and then random
// phases of sender idling and receiver back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_quaternion_arithmetic_unit;
  import qau_pkg::*;

  localparam int IDLE_LIMIT  = 1000;  // cycles with no transfer on either side
  localparam int PHASE_ITEMS = 235;

  logic clk;
  logic rst;

  qau_req_if req_ch ();
  qau_rsp_if rsp_ch ();

  quaternion_arithmetic_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  item_t   operand_queue[$];
  result_t expected_quats[$];

  int unsigned items_offered  = 0;
  int unsigned items_taken    = 0;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic longint round_q14(input longint v);
    return (v + 64'sd8192) >>> 14;  // floor after adding half: ties go up
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic result_t quat_eval(input item_t it);
    longint  x, y, z, w, bx, by, bz, bw, f, s, c;
    longint  v[4];
    bit      is_scalar;
    bit      ovf;
    result_t r;
    x = it.ax; y = it.ay; z = it.az; w = it.aw;
    bx = it.bx; by = it.by; bz = it.bz; bw = it.bw;
    f = it.factor;
    s = 0;
    is_scalar = 1'b0;
    ovf = 1'b0;
    foreach (v[k]) v[k] = 0;
    case (it.op)
      OP_MUL: begin
        v[0] = round_q14(w * bx + x * bw + y * bz - z * by);
        v[1] = round_q14(w * by - x * bz + y * bw + z * bx);
        v[2] = round_q14(w * bz + x * by - y * bx + z * bw);
        v[3] = round_q14(w * bw - x * bx - y * by - z * bz);
      end
      OP_ADD: begin
        v[0] = x + bx; v[1] = y + by; v[2] = z + bz; v[3] = w + bw;
      end
      OP_SUB: begin
        v[0] = x - bx; v[1] = y - by; v[2] = z - bz; v[3] = w - bw;
      end
      OP_SCL: begin
        v[0] = round_q14(x * f); v[1] = round_q14(y * f);
        v[2] = round_q14(z * f); v[3] = round_q14(w * f);
      end
      OP_NEG: begin
        v[0] = -x; v[1] = -y; v[2] = -z; v[3] = -w;
      end
      OP_CONJ: begin
        v[0] = -x; v[1] = -y; v[2] = -z; v[3] = w;
      end
      OP_DOT: begin
        s = x * bx + y * by + z * bz + w * bw;
        is_scalar = 1'b1;
      end
      default: begin
        s = x * x + y * y + z * z + w * w;
        is_scalar = 1'b1;
      end
    endcase
    r = '0;
    if (is_scalar) begin
      c = clip(s, -64'sd2147483648, 64'sd2147483647);
      ovf = (c != s);
      r.scalar_out = 32'(c);
    end else begin
      foreach (v[k]) begin
        c = clip(v[k], -64'sd32768, 64'sd32767);
        if (c != v[k]) ovf = 1'b1;
        v[k] = c;
      end
      r.rx = q14_t'(v[0]);
      r.ry = q14_t'(v[1]);
      r.rz = q14_t'(v[2]);
      r.rw = q14_t'(v[3]);
    end
    r.overflow = ovf;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic item_t mk_item(input op_t op, input int ax, input int ay,
                                    input int az, input int aw, input int bx,
                                    input int by, input int bz, input int bw,
                                    input int fac);
    item_t it;
    it.op = op;
    it.ax = q14_t'(ax); it.ay = q14_t'(ay); it.az = q14_t'(az); it.aw = q14_t'(aw);
    it.bx = q14_t'(bx); it.by = q14_t'(by); it.bz = q14_t'(bz); it.bw = q14_t'(bw);
    it.factor = q14_t'(fac);
    return it;
  endfunction

  // A mix of unit-range, near-zero, full-range and extreme values.
  function automatic int rand_q14();
    int pick;
    pick = $urandom_range(9);
    case (pick)
      0:       return 32767;
      1:       return -32768;
      2, 3, 4: return int'($urandom_range(32768)) - 16384;
      5:       return int'($urandom_range(64)) - 32;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  function automatic item_t rand_item();
    return mk_item(op_t'($urandom_range(7)), rand_q14(), rand_q14(), rand_q14(),
                   rand_q14(), rand_q14(), rand_q14(), rand_q14(), rand_q14(),
                   rand_q14());
  endfunction

  task automatic wait_drained();
    while (operand_queue.size() != 0 || items_offered != items_taken ||
           expected_quats.size() != 0)
      @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: present the next item once the previous one transferred
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_req
    item_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (items_offered == items_taken) begin
      if (operand_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = operand_queue.pop_front();
        req_ch.op     <= nxt.op;
        req_ch.ax     <= nxt.ax;
        req_ch.ay     <= nxt.ay;
        req_ch.az     <= nxt.az;
        req_ch.aw     <= nxt.aw;
        req_ch.bx     <= nxt.bx;
        req_ch.by     <= nxt.by;
        req_ch.bz     <= nxt.bz;
        req_ch.bw     <= nxt.bw;
        req_ch.factor <= nxt.factor;
        req_ch.valid  <= 1'b1;
        items_offered <= items_offered + 1;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on request transfer, check on response transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    item_t   seen;
    result_t got;
    result_t want;
    bit      bad;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        seen.op = op_t'(req_ch.op);
        seen.ax = req_ch.ax; seen.ay = req_ch.ay; seen.az = req_ch.az;
        seen.aw = req_ch.aw; seen.bx = req_ch.bx; seen.by = req_ch.by;
        seen.bz = req_ch.bz; seen.bw = req_ch.bw; seen.factor = req_ch.factor;
        expected_quats.push_back(quat_eval(seen));
        items_taken = items_taken + 1;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.rx = rsp_ch.rx; got.ry = rsp_ch.ry; got.rz = rsp_ch.rz;
        got.rw = rsp_ch.rw; got.scalar_out = rsp_ch.scalar_out;
        got.overflow = rsp_ch.overflow;
        if (expected_quats.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10)
            $display("%0t: response with nothing outstanding: x=%0d y=%0d z=%0d w=%0d s=%0d ovf=%0b",
                     $realtime, got.rx, got.ry, got.rz, got.rw, got.scalar_out, got.overflow);
        end else begin
          want = expected_quats.pop_front();
          bad = (got.rx !== want.rx) || (got.ry !== want.ry) || (got.rz !== want.rz) ||
                (got.rw !== want.rw) || (got.scalar_out !== want.scalar_out) ||
                (got.overflow !== want.overflow);
          if (bad) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10) begin
              $display("%0t: mismatch exp x=%0d y=%0d z=%0d w=%0d s=%0d ovf=%0b",
                       $realtime, want.rx, want.ry, want.rz, want.rw, want.scalar_out,
                       want.overflow);
              $display("%0t:          got x=%0d y=%0d z=%0d w=%0d s=%0d ovf=%0b",
                       $realtime, got.rx, got.ry, got.rz, got.rw, got.scalar_out,
                       got.overflow);
            end
          end
        end
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.op = OP_MUL;
    req_ch.ax = '0; req_ch.ay = '0; req_ch.az = '0; req_ch.aw = '0;
    req_ch.bx = '0; req_ch.by = '0; req_ch.bz = '0; req_ch.bw = '0;
    req_ch.factor = '0;
    rsp_ch.ready = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Identity, max negative everywhere, mixed extremes
    operand_queue.push_back(mk_item(OP_MUL, 0, 0, 0, 16384, 1234, -4321, 777, -16384, 0));
    operand_queue.push_back(mk_item(OP_MUL, -32768, -32768, -32768, -32768,
                                    -32768, -32768, -32768, -32768, 0));
    operand_queue.push_back(mk_item(OP_MUL, 32767, -32768, 32767, -32768,
                                    -32768, 32767, 32767, -32768, 32767));
    operand_queue.push_back(mk_item(OP_MUL, 1, 0, 0, 0, 8192, 0, 0, 0, 0));
    // Sums and differences past both rails
    operand_queue.push_back(mk_item(OP_ADD, 32767, -32768, 100, -100,
                                    32767, -32768, -100, 100, 0));
    operand_queue.push_back(mk_item(OP_SUB, 32767, -32768, 0, -1,
                                    -32768, 32767, 0, 32767, 0));
    // Scale: overflow on both signs and ties rounding upward
    operand_queue.push_back(mk_item(OP_SCL, -32768, 32767, 1, -1, 0, 0, 0, 0, -32768));
    operand_queue.push_back(mk_item(OP_SCL, 32767, -32768, 3, -3, 0, 0, 0, 0, 32767));
    operand_queue.push_back(mk_item(OP_SCL, 1, -1, 3, -3, 0, 0, 0, 0, 8192));
    // Negating the most negative value
    operand_queue.push_back(mk_item(OP_NEG, -32768, 32767, 0, 1, 5, 6, 7, 8, 9));
    operand_queue.push_back(mk_item(OP_NEG, 1, -1, 16384, -16384, 0, 0, 0, 0, 0));
    operand_queue.push_back(mk_item(OP_CONJ, -32768, 0, 0, -32768, 0, 0, 0, 0, 0));
    operand_queue.push_back(mk_item(OP_CONJ, 100, 32767, -200, -32768, 0, 0, 0, 0, 0));
    // Scalar clamp on both rails
    operand_queue.push_back(mk_item(OP_DOT, -32768, -32768, -32768, -32768,
                                    -32768, -32768, -32768, -32768, 0));
    operand_queue.push_back(mk_item(OP_DOT, -32768, -32768, -32768, -32768,
                                    32767, 32767, 32767, 32767, 0));
    operand_queue.push_back(mk_item(OP_DOT, 16384, 0, -8192, 3, 16384, 9, 8192, -5, 0));
    operand_queue.push_back(mk_item(OP_LEN2, -32768, -32768, -32768, -32768,
                                    1, 2, 3, 4, 5));
    operand_queue.push_back(mk_item(OP_LEN2, 16384, 0, 0, 0, 0, 0, 0, 0, 0));
    operand_queue.push_back(mk_item(OP_LEN2, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    operand_queue.push_back(mk_item(OP_LEN2, -32768, 32767, 0, 0, 0, 0, 0, 0, 0));
    // Hold the sender until everything has come back
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      repeat (PHASE_ITEMS) operand_queue.push_back(rand_item());
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
